// ----- rtl/bptc_pkg.sv -----
`default_nettype none

package bptc_pkg;

  // Field widths of the raw conversions, calibration words and results.
  localparam int RAW_W    = 24;
  localparam int CAL_W    = 16;
  localparam int TEMP_W   = 19;
  localparam int PRES_W   = 32;
  localparam int CFG_IDX_W = 3;

  // Internal widths: temperature difference, first products, dT squared,
  // squared temperature offsets, offset and sensitivity, full pressure product.
  localparam int DT_W   = 25;
  localparam int MUL_W  = 42;
  localparam int DD_W   = 50;
  localparam int DDS_W  = 48;
  localparam int SQ_W   = 38;
  localparam int F_W    = 35;
  localparam int T2_W   = 17;
  localparam int OFF_W  = 40;
  localparam int LO_W   = 44;
  localparam int HI_W   = 45;
  localparam int PROD_W = 64;

  // Temperature thresholds in hundredths of a degree.
  localparam logic signed [TEMP_W-1:0] TEMP_REF   = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VCOLD = -19'sd1500;

  // Calibration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFF       = 3'd1,
    REG_SENS_TEMP = 3'd2,
    REG_OFF_TEMP  = 3'd3,
    REG_TEMP_REF  = 3'd4,
    REG_TEMP_SENS = 3'd5
  } cfg_idx_t;

  // Calibration words as held in the register file.
  typedef struct packed {
    logic [CAL_W-1:0] sens_coeff;
    logic [CAL_W-1:0] offset_coeff;
    logic [CAL_W-1:0] sens_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] ref_temp_word;
    logic [CAL_W-1:0] temp_slope_coeff;
  } cal_t;

  // Compensated sample handed from the temperature path to the pressure path.
  typedef struct packed {
    logic                     valid;
    logic [RAW_W-1:0]         raw_pressure;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [OFF_W-1:0]  sens;
  } comp_t;

endpackage

`default_nettype wire

// ----- rtl/bptc_cfg_regs.sv -----
`default_nettype none

module bptc_cfg_regs import bptc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_data,
  output cal_t                      cal
);

  cal_t cal_r;
  cal_t cal_nxt;

  // Decode the register index; indexes beyond the list are ignored.
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_SENS:      cal_nxt.sens_coeff        = cfg_data;
        REG_OFF:       cal_nxt.offset_coeff      = cfg_data;
        REG_SENS_TEMP: cal_nxt.sens_temp_coeff   = cfg_data;
        REG_OFF_TEMP:  cal_nxt.offset_temp_coeff = cfg_data;
        REG_TEMP_REF:  cal_nxt.ref_temp_word     = cfg_data;
        REG_TEMP_SENS: cal_nxt.temp_slope_coeff  = cfg_data;
        default:       cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

`default_nettype wire

// ----- rtl/bptc_temp_path.sv -----
`default_nettype none

module bptc_temp_path import bptc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [RAW_W-1:0] raw_pressure,
  input  wire logic [RAW_W-1:0] raw_temperature,
  input  wire cal_t             cal,
  output comp_t                 comp
);

  // Valid bits, one per stage.
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;

  // Raw pressure carried alongside the temperature work.
  logic [RAW_W-1:0] s1_d1_r, s2_d1_r, s3_d1_r, s4_d1_r, s5_d1_r, s6_d1_r;

  // Stage 1: temperature difference from the reference.
  logic signed [DT_W-1:0] d2_ext, tref_ext, dt_nxt, s1_dt_r;

  // Stage 2: the four products on dT.
  logic signed [MUL_W-1:0] tsc_ext, otc_ext, stc_ext, dt_ext;
  logic signed [MUL_W-1:0] p_tsc_nxt, p_otc_nxt, p_stc_nxt;
  logic signed [MUL_W-1:0] s2_p_tsc_r, s2_p_otc_r, s2_p_stc_r;
  logic signed [DD_W-1:0]  dd_full;
  logic [DDS_W-1:0]        s2_p_dd_r;

  // Stage 3: first-order temperature, offset and sensitivity.
  logic signed [TEMP_W-1:0] tdiff_nxt, temp1_nxt, tcold_nxt;
  logic signed [34:0]       otc_sh;
  logic signed [33:0]       stc_sh;
  logic signed [OFF_W-1:0]  off_base, sens_base, off1_nxt, sens1_nxt;
  logic signed [TEMP_W-1:0] s3_tdiff_r, s3_temp1_r, s3_tcold_r;
  logic signed [OFF_W-1:0]  s3_off1_r, s3_sens1_r;
  logic [T2_W-1:0]          s3_t2_r;
  logic                     s3_cold_r, s3_vcold_r;

  // Stage 4: squares of the temperature offsets.
  logic signed [SQ_W-1:0]   f_full, g_full;
  logic [F_W-1:0]           s4_f_r, s4_g_r;
  logic signed [TEMP_W-1:0] s4_temp1_r;
  logic signed [OFF_W-1:0]  s4_off1_r, s4_sens1_r;
  logic [T2_W-1:0]          s4_t2_r;
  logic                     s4_cold_r, s4_vcold_r;

  // Stage 5: second-order corrections.
  logic [OFF_W-1:0]         f_ext, g_ext, f5, g7, g11, off2_nxt, sens2_nxt;
  logic [T2_W-1:0]          t2_nxt;
  logic [OFF_W-1:0]         s5_off2_r, s5_sens2_r;
  logic [T2_W-1:0]          s5_t2_r;
  logic signed [TEMP_W-1:0] s5_temp1_r;
  logic signed [OFF_W-1:0]  s5_off1_r, s5_sens1_r;

  // Stage 6: corrected results.
  logic signed [TEMP_W-1:0] s6_temp_r;
  logic signed [OFF_W-1:0]  s6_off_r, s6_sens_r;

  // Stage 1 logic: dT = D2 - C5 * 256.
  always_comb begin
    d2_ext   = {1'b0, raw_temperature};
    tref_ext = {1'b0, cal.ref_temp_word, 8'h00};
    dt_nxt   = d2_ext - tref_ext;
  end

  // Stage 2 logic: one multiplier for each coefficient, and dT squared.
  always_comb begin
    dt_ext    = MUL_W'(s1_dt_r);
    tsc_ext   = MUL_W'({1'b0, cal.temp_slope_coeff});
    otc_ext   = MUL_W'({1'b0, cal.offset_temp_coeff});
    stc_ext   = MUL_W'({1'b0, cal.sens_temp_coeff});
    p_tsc_nxt = dt_ext * tsc_ext;
    p_otc_nxt = otc_ext * dt_ext;
    p_stc_nxt = stc_ext * dt_ext;
    dd_full   = DD_W'(s1_dt_r) * DD_W'(s1_dt_r);
  end

  // Stage 3 logic: the arithmetic shifts floor, so plain part-selects do.
  always_comb begin
    tdiff_nxt = s2_p_tsc_r[MUL_W-1:23];
    temp1_nxt = tdiff_nxt + TEMP_REF;
    tcold_nxt = temp1_nxt - TEMP_VCOLD;
    otc_sh    = s2_p_otc_r[MUL_W-1:7];
    stc_sh    = s2_p_stc_r[MUL_W-1:8];
    off_base  = {8'h00, cal.offset_coeff, 16'h0000};
    sens_base = {9'h000, cal.sens_coeff, 15'h0000};
    off1_nxt  = off_base + OFF_W'(otc_sh);
    sens1_nxt = sens_base + OFF_W'(stc_sh);
  end

  // Stage 4 logic: squares of (TEMP - 2000) and (TEMP + 1500).
  always_comb begin
    f_full = SQ_W'(s3_tdiff_r) * SQ_W'(s3_tdiff_r);
    g_full = SQ_W'(s3_tcold_r) * SQ_W'(s3_tcold_r);
  end

  // Stage 5 logic: scale the squares by shifts and adds; nothing applies when warm.
  always_comb begin
    f_ext     = OFF_W'(s4_f_r);
    g_ext     = OFF_W'(s4_g_r);
    f5        = (f_ext << 2) + f_ext;
    g7        = (g_ext << 3) - g_ext;
    g11       = (g_ext << 3) + (g_ext << 1) + g_ext;
    off2_nxt  = '0;
    sens2_nxt = '0;
    t2_nxt    = '0;
    if (s4_cold_r) begin
      off2_nxt  = f5 >> 1;
      sens2_nxt = f5 >> 2;
      t2_nxt    = s4_t2_r;
      if (s4_vcold_r) begin
        off2_nxt  = (f5 >> 1) + g7;
        sens2_nxt = (f5 >> 2) + (g11 >> 1);
      end
    end
  end

  // Valid bits travel down the pipe; cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
    end
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    s1_d1_r    <= raw_pressure;
    s1_dt_r    <= dt_nxt;

    s2_d1_r    <= s1_d1_r;
    s2_p_tsc_r <= p_tsc_nxt;
    s2_p_otc_r <= p_otc_nxt;
    s2_p_stc_r <= p_stc_nxt;
    s2_p_dd_r  <= dd_full[DDS_W-1:0];

    s3_d1_r    <= s2_d1_r;
    s3_tdiff_r <= tdiff_nxt;
    s3_temp1_r <= temp1_nxt;
    s3_tcold_r <= tcold_nxt;
    s3_off1_r  <= off1_nxt;
    s3_sens1_r <= sens1_nxt;
    s3_t2_r    <= s2_p_dd_r[DDS_W-1:31];
    s3_cold_r  <= tdiff_nxt[TEMP_W-1];
    s3_vcold_r <= (temp1_nxt < TEMP_VCOLD);

    s4_d1_r    <= s3_d1_r;
    s4_f_r     <= f_full[F_W-1:0];
    s4_g_r     <= g_full[F_W-1:0];
    s4_temp1_r <= s3_temp1_r;
    s4_off1_r  <= s3_off1_r;
    s4_sens1_r <= s3_sens1_r;
    s4_t2_r    <= s3_t2_r;
    s4_cold_r  <= s3_cold_r;
    s4_vcold_r <= s3_vcold_r;

    s5_d1_r    <= s4_d1_r;
    s5_off2_r  <= off2_nxt;
    s5_sens2_r <= sens2_nxt;
    s5_t2_r    <= t2_nxt;
    s5_temp1_r <= s4_temp1_r;
    s5_off1_r  <= s4_off1_r;
    s5_sens1_r <= s4_sens1_r;

    s6_d1_r    <= s5_d1_r;
    s6_temp_r  <= s5_temp1_r - TEMP_W'(s5_t2_r);
    s6_off_r   <= s5_off1_r - signed'(s5_off2_r);
    s6_sens_r  <= s5_sens1_r - signed'(s5_sens2_r);
  end

  assign comp = '{valid:        s6_valid_r,
                  raw_pressure: s6_d1_r,
                  temp:         s6_temp_r,
                  off:          s6_off_r,
                  sens:         s6_sens_r};

endmodule

`default_nettype wire

// ----- rtl/bptc_press_path.sv -----
`default_nettype none

module bptc_press_path import bptc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire comp_t               comp,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temp_centideg,
  output logic signed [PRES_W-1:0] out_pressure_out
);

  logic s7_valid_r, s8_valid_r, out_valid_r;

  logic signed [DT_W-1:0]   d1_s;
  logic signed [19:0]       sens_hi;
  logic signed [HI_W-1:0]   hi_nxt, s7_hi_r;
  logic [LO_W-1:0]          lo_nxt, s7_lo_r;
  logic signed [TEMP_W-1:0] s7_temp_r, s8_temp_r, out_temp_r;
  logic signed [OFF_W-1:0]  s7_off_r, s8_off_r;
  logic signed [PROD_W-1:0] prod_nxt, s8_prod_r, p_full;
  logic signed [PRES_W-1:0] out_pressure_r;

  // Stage 7: D1 * SENS as two partial products on the halves of SENS.
  always_comb begin
    d1_s    = {1'b0, comp.raw_pressure};
    sens_hi = comp.sens[OFF_W-1:20];
    hi_nxt  = HI_W'(d1_s) * HI_W'(sens_hi);
    lo_nxt  = LO_W'(comp.raw_pressure) * LO_W'(comp.sens[19:0]);
  end

  // Stage 8: add the partial products back together.
  always_comb begin
    prod_nxt = (PROD_W'(s7_hi_r) <<< 20) + signed'(PROD_W'(s7_lo_r));
  end

  // Stage 9: P = ((D1 * SENS >> 21) - OFF) >> 15, low 32 bits kept.
  always_comb begin
    p_full = (s8_prod_r >>> 21) - PROD_W'(s8_off_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r  <= 1'b0;
      s8_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s7_valid_r  <= comp.valid;
      s8_valid_r  <= s7_valid_r;
      out_valid_r <= s8_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_hi_r        <= hi_nxt;
    s7_lo_r        <= lo_nxt;
    s7_temp_r      <= comp.temp;
    s7_off_r       <= comp.off;
    s8_prod_r      <= prod_nxt;
    s8_temp_r      <= s7_temp_r;
    s8_off_r       <= s7_off_r;
    out_temp_r     <= s8_temp_r;
    out_pressure_r <= p_full[46:15];
  end

  assign out_valid         = out_valid_r;
  assign out_temp_centideg = out_temp_r;
  assign out_pressure_out  = out_pressure_r;

endmodule

`default_nettype wire

// ----- rtl/baro_pressure_temp_compensation.sv -----
// Channel   Ports                                                  Transaction
// input     start, busy, in_raw_pressure, in_raw_temperature       start high, busy low
// result    out_valid, out_temp_centideg, out_pressure_out         out_valid high, one cycle
// config    cfg_we, cfg_index, cfg_data                            cfg_we high
//
// One sample pair enters every cycle while busy is low; the result comes out of
// the nine-stage pipeline, two stages of which hold the split 24 by 40 bit
// pressure product.
// Synchronous reset clears the valid bits and the calibration words; busy is
// high only in the cycle after a reset edge.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module baro_pressure_temp_compensation import bptc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [RAW_W-1:0]     in_raw_pressure,
  input  wire logic [RAW_W-1:0]     in_raw_temperature,
  output logic                      out_valid,
  output logic signed [TEMP_W-1:0]  out_temp_centideg,
  output logic signed [PRES_W-1:0]  out_pressure_out,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_data
);

  cal_t  cal;
  comp_t comp;
  logic  busy_r;
  logic  in_take;

  // Busy marks the cycle straight after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy    = busy_r;
  assign in_take = start && !busy_r;

  bptc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  bptc_temp_path u_temp_path (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_take),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .cal             (cal),
    .comp            (comp)
  );

  bptc_press_path u_press_path (
    .clk               (clk),
    .rst_n             (rst_n),
    .comp              (comp),
    .out_valid         (out_valid),
    .out_temp_centideg (out_temp_centideg),
    .out_pressure_out  (out_pressure_out)
  );

endmodule

`default_nettype wire

// ----- rtl/bptc_checker.sv -----
`default_nettype none

module bptc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // Every accepted transaction yields a result once it has passed through the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##9 out_valid)
    else $error("accepted transaction produced no result");

  // No result without a matching accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 9))
    else $error("result without a matching transaction");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Busy is only raised by reset.
  a_busy_reset: assert property (@(posedge clk)
    rst_n |=> !busy)
    else $error("busy high outside reset");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb_baro_pressure_temp_compensation.sv -----
`default_nettype none

module tb_baro_pressure_temp_compensation;
  import bptc_pkg::*;

  localparam int PIPE_LATENCY = 9;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1200;

  // Register indexes that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  localparam logic [RAW_W-1:0] TYP_D1  = 24'd9085466;
  localparam logic [CAL_W-1:0] CAL_MAX = '1;

  // One raw conversion pair and one compensated reading.
  typedef struct {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } sample_t;

  typedef struct {
    logic signed [TEMP_W-1:0] temp_centideg;
    logic signed [PRES_W-1:0] pressure_out;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [RAW_W-1:0] in_raw_pressure = '0;
  logic [RAW_W-1:0] in_raw_temperature = '0;
  logic out_valid;
  logic signed [TEMP_W-1:0] out_temp_centideg;
  logic signed [PRES_W-1:0] out_pressure_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0] cfg_data = '0;

  sample_t  sample_q[$];
  reading_t reading_q[$];
  cal_t     cal_shadow;
  bit       mismatch_seen = 1'b0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;

  baro_pressure_temp_compensation u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .out_valid          (out_valid),
    .out_temp_centideg  (out_temp_centideg),
    .out_pressure_out   (out_pressure_out),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Second-order compensation of one pair with the calibration words held now.
  function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, dt, temp, off, sens, t2, f, g, off2, sens2, p;
    longint c1, c2, c3, c4, c5, c6;
    reading_t r;
    c1 = longint'(cal_shadow.sens_coeff);
    c2 = longint'(cal_shadow.offset_coeff);
    c3 = longint'(cal_shadow.sens_temp_coeff);
    c4 = longint'(cal_shadow.offset_temp_coeff);
    c5 = longint'(cal_shadow.ref_temp_word);
    c6 = longint'(cal_shadow.temp_slope_coeff);
    d1 = longint'(d1_raw);
    d2 = longint'(d2_raw);
    dt = d2 - (c5 <<< 8);
    temp = longint'(TEMP_REF) + ((dt * c6) >>> 23);
    off = (c2 <<< 16) + ((c4 * dt) >>> 7);
    sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
    // Below 20.00 C the second-order terms apply, with more below -15.00 C.
    if (temp < longint'(TEMP_REF)) begin
      t2 = (dt * dt) >>> 31;
      f = (temp - longint'(TEMP_REF)) * (temp - longint'(TEMP_REF));
      off2 = (5 * f) >>> 1;
      sens2 = (5 * f) >>> 2;
      if (temp < longint'(TEMP_VCOLD)) begin
        g = (temp - longint'(TEMP_VCOLD)) * (temp - longint'(TEMP_VCOLD));
        off2 = off2 + 7 * g;
        sens2 = sens2 + ((11 * g) >>> 1);
      end
      temp = temp - t2;
      off = off - off2;
      sens = sens - sens2;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temp_centideg = temp[TEMP_W-1:0];
    r.pressure_out = p[PRES_W-1:0];
    return r;
  endfunction

  // Raw temperature that lands the first-order result near 2000 plus t_off.
  function automatic logic [RAW_W-1:0] raw_temp_for(input longint t_off);
    longint dt, d2;
    if (cal_shadow.temp_slope_coeff == 0) begin
      dt = longint'($urandom_range(0, 2000)) - 1000;
    end else begin
      dt = (t_off <<< 23) / longint'(cal_shadow.temp_slope_coeff);
    end
    d2 = dt + (longint'(cal_shadow.ref_temp_word) <<< 8);
    if (d2 < 0) begin
      d2 = 0;
    end else if (d2 > longint'(RAW_MAX)) begin
      d2 = longint'(RAW_MAX);
    end
    return d2[RAW_W-1:0];
  endfunction

  function automatic logic [CAL_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CAL_MAX;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
    sample_t s;
    s.raw_pressure = p;
    s.raw_temperature = t;
    sample_q.push_back(s);
  endtask

  // Random pairs, weighted towards the cold thresholds and the field extremes.
  task automatic push_random(input int count);
    logic [RAW_W-1:0] p, t;
    int k;
    longint t_off;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: p = '0;
        1: p = RAW_MAX;
        2, 3: p = RAW_W'(TYP_D1 + $urandom_range(0, 400000) - 200000);
        default: p = RAW_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t = RAW_W'($urandom);
        4, 5, 6, 7: begin
          t_off = ($urandom_range(0, 1) == 0) ? 0 : -3500;
          t_off = t_off + longint'($urandom_range(0, 40)) - 20;
          t = raw_temp_for(t_off);
        end
        8: t = ($urandom_range(0, 1) == 0) ? '0 : RAW_MAX;
        default: t = raw_temp_for(-longint'($urandom_range(3500, 40000)));
      endcase
      push_sample(p, t);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  // Loads all six calibration words, with stray writes to the unused indexes.
  task automatic load_cal(input cal_t c);
    cfg_write(REG_SPARE_A, CAL_W'($urandom));
    cfg_write(REG_SENS, c.sens_coeff);
    cfg_write(REG_OFF, c.offset_coeff);
    cfg_write(REG_SENS_TEMP, c.sens_temp_coeff);
    cfg_write(REG_SPARE_B, CAL_W'($urandom));
    cfg_write(REG_OFF_TEMP, c.offset_temp_coeff);
    cfg_write(REG_TEMP_REF, c.ref_temp_word);
    cfg_write(REG_TEMP_SENS, c.temp_slope_coeff);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every queued transaction has gone in and every reading has come out.
  task automatic settle();
    while (sample_q.size() != 0 || start || reading_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // Mirror of the calibration registers, updated on the same edge as the block's.
  always @(posedge clk) begin
    if (!rst_n) begin
      cal_shadow <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS:      cal_shadow.sens_coeff <= cfg_data;
        REG_OFF:       cal_shadow.offset_coeff <= cfg_data;
        REG_SENS_TEMP: cal_shadow.sens_temp_coeff <= cfg_data;
        REG_OFF_TEMP:  cal_shadow.offset_temp_coeff <= cfg_data;
        REG_TEMP_REF:  cal_shadow.ref_temp_word <= cfg_data;
        REG_TEMP_SENS: cal_shadow.temp_slope_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // Driver: records each accepted transaction and presents the next pair in bursts.
  always @(posedge clk) begin : driver
    sample_t item;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reading_q.push_back(compensate(in_raw_pressure, in_raw_temperature));
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0) begin
          item = sample_q.pop_front();
          start <= 1'b1;
          in_raw_pressure <= item.raw_pressure;
          in_raw_temperature <= item.raw_temperature;
          if (burst_left <= 1) begin
            // A long burst now and then keeps the pipeline full for a while.
            if ($urandom_range(0, 5) == 0) begin
              burst_left <= $urandom_range(30, 100);
              gap_left <= 0;
            end else begin
              burst_left <= $urandom_range(1, 16);
              gap_left <= $urandom_range(0, 12);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each reading is checked against the oldest one expected.
  always @(posedge clk) begin : monitor
    reading_t want;
    if (rst_n && out_valid) begin
      if (reading_q.size() == 0) begin
        $error("reading with none expected: temp_centideg %0d, pressure_out %0d",
               out_temp_centideg, out_pressure_out);
        mismatch_seen = 1'b1;
      end else begin
        want = reading_q.pop_front();
        if (out_temp_centideg !== want.temp_centideg) begin
          $error("temp_centideg: expected %0d, got %0d", want.temp_centideg,
                 out_temp_centideg);
          mismatch_seen = 1'b1;
        end
        if (out_pressure_out !== want.pressure_out) begin
          $error("pressure_out: expected %0d, got %0d", want.pressure_out,
                 out_pressure_out);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_baro_pressure_temp_compensation: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    cal_t cal;
    int total, phase, n_items;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // With the calibration words still at reset.
    push_sample('0, '0);
    push_sample(RAW_MAX, RAW_MAX);
    settle();

    // Typical calibration: field extremes and both cold thresholds.
    cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
    load_cal(cal);
    push_sample('0, raw_temp_for(0));
    push_sample(RAW_MAX, raw_temp_for(0));
    push_sample('0, '0);
    push_sample(RAW_MAX, '0);
    push_sample('0, RAW_MAX);
    push_sample(RAW_MAX, RAW_MAX);
    push_sample(TYP_D1, raw_temp_for(0));
    push_sample(TYP_D1, raw_temp_for(-1));
    push_sample(TYP_D1, raw_temp_for(-3500));
    push_sample(TYP_D1, raw_temp_for(-3501));
    push_sample(RAW_MAX, raw_temp_for(-3501));
    push_sample(TYP_D1, raw_temp_for(-20000));
    push_sample(TYP_D1, 24'd8077636);
    push_sample(24'h555555, 24'hAAAAAA);
    push_sample(24'hAAAAAA, 24'h555555);
    settle();

    // All words at their maximum, then the corners of the raw fields.
    cal = '{CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX};
    load_cal(cal);
    push_sample('0, '0);
    push_sample(RAW_MAX, '0);
    push_sample('0, RAW_MAX);
    push_sample(RAW_MAX, RAW_MAX);
    settle();

    // Random phases; each pauses halfway until the pipeline has drained.
    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      case (phase)
        0: cal = '{CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX};
        1: cal = '0;
        2: cal = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        default: begin
          cal = '{pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                  pick_word()};
        end
      endcase
      load_cal(cal);
      n_items = $urandom_range(100, 200);
      push_random(n_items / 2);
      settle();
      push_random(n_items - n_items / 2);
      settle();
      total += n_items;
      phase++;
    end

    if (reading_q.size() != 0) begin
      $error("%0d readings never arrived", reading_q.size());
      mismatch_seen = 1'b1;
    end
    if (!mismatch_seen) begin
      $display("tb_baro_pressure_temp_compensation: PASS");
    end else begin
      $display("tb_baro_pressure_temp_compensation: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- baro_pressure_temp_compensation.f -----
rtl/bptc_pkg.sv
rtl/bptc_cfg_regs.sv
rtl/bptc_temp_path.sv
rtl/bptc_press_path.sv
rtl/baro_pressure_temp_compensation.sv
rtl/bptc_checker.sv
tb/tb_baro_pressure_temp_compensation.sv
